>>> design/adc_block_average_iir_angle_defines.svh
// Assertion macros shared by the block's RTL files.
`ifndef ADC_BLOCK_AVERAGE_IIR_ANGLE_DEFINES_SVH
`define ADC_BLOCK_AVERAGE_IIR_ANGLE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define ABAI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ABAI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ABAI_ASSERT_IMP(name, ante, cons)
`define ABAI_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> design/abai_pkg.sv
// Shared constants, types and codes of the block average / IIR / angle block.
package abai_pkg;

  localparam int BLOCK_SAMPLES = 2048;
  localparam int DECIMATION    = 8;
  localparam int SAMPLE_BITS   = 12;

  // taken samples per block; must be a power of two (average is a shift)
  localparam int TAKEN_COUNT = (BLOCK_SAMPLES + DECIMATION - 1) / DECIMATION;
  localparam int AVG_SHIFT   = $clog2(TAKEN_COUNT);

  localparam int POS_W = $clog2(BLOCK_SAMPLES);
  localparam int DEC_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int SUM_W = SAMPLE_BITS + AVG_SHIFT;

  localparam int FRAC_BITS   = 16;
  localparam int Y_W         = SAMPLE_BITS + FRAC_BITS;
  localparam int DIFF_W      = Y_W + 1;
  localparam int GAIN_W      = 17;
  localparam int COUNT_W     = 12;
  localparam int SLOPE_W     = 16;
  localparam int ANGLE_W     = 16;
  localparam int COEF_W      = GAIN_W + 1;
  localparam int PROD_W      = COEF_W + DIFF_W;
  localparam int ANGLE_SHIFT = 24;
  localparam int ANGLE_MAX_Q8 = 46080;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [GAIN_W-1:0]  GAIN_RST    = GAIN_W'(6554);
  localparam logic [COUNT_W-1:0] COUNT_RST   = COUNT_W'(300);
  localparam logic [SLOPE_W-1:0] SLOPE_RST   = SLOPE_W'(3370);
  localparam logic [ANGLE_W-1:0] ANG_OFF_RST = ANGLE_W'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_GAIN  = 2'd0,
    CFG_COUNT_OFFSET = 2'd1,
    CFG_SLOPE        = 2'd2,
    CFG_ANGLE_OFFSET = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_FILT_MUL,
    ST_FILT_UPD,
    ST_ANG_MUL,
    ST_ANG_OUT
  } seq_state_t;

  typedef enum logic {
    MAC_FILTER,
    MAC_ANGLE
  } mac_sel_t;

  typedef struct packed {
    logic     load;
    mac_sel_t sel;
  } mac_ctrl_t;

endpackage

>>> design/abai_accum.sv
// Sample position, decimation phase and block sum; latches the block average.
`include "adc_block_average_iir_angle_defines.svh"

module abai_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take_en,
  input  logic [abai_pkg::SAMPLE_BITS-1:0] sample,
  output logic                         block_done,
  output logic [abai_pkg::Y_W-1:0]     avg
);
  import abai_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [DEC_W-1:0] phase_r, phase_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [Y_W-1:0]   avg_r;
  logic [SUM_W-1:0] sum_add;
  logic [SUM_W+FRAC_BITS-1:0] scaled;
  logic             last_pos;

  assign last_pos   = (pos_r == POS_W'(BLOCK_SAMPLES - 1));
  assign sum_add    = sum_r + ((phase_r == '0) ? SUM_W'(sample) : '0);
  assign scaled     = {sum_add, {FRAC_BITS{1'b0}}} >> AVG_SHIFT;
  assign block_done = take_en & last_pos;
  assign avg        = avg_r;

  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    if (take_en) begin
      if (last_pos) begin
        pos_nxt   = '0;
        phase_nxt = '0;
        sum_nxt   = '0;
      end else begin
        pos_nxt   = pos_r + 1'b1;
        phase_nxt = (phase_r == DEC_W'(DECIMATION - 1)) ? '0 : phase_r + 1'b1;
        sum_nxt   = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= '0;
      sum_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (block_done) begin
      avg_r <= Y_W'(scaled);
    end
  end

  // block start must line up with decimation phase zero
  `ABAI_ASSERT_IMP(a_phase_at_start, pos_r == '0, phase_r == '0)

endmodule

>>> design/abai_mac.sv
// Shared signed multiplier: coefficient times difference, registered product.
module abai_mac (
  input  logic                          clk,
  input  abai_pkg::mac_ctrl_t           ctrl,
  input  logic [abai_pkg::GAIN_W-1:0]   gain,
  input  logic [abai_pkg::SLOPE_W-1:0]  slope,
  input  logic [abai_pkg::COUNT_W-1:0]  count_offset,
  input  logic [abai_pkg::Y_W-1:0]      avg,
  input  logic [abai_pkg::Y_W-1:0]      y,
  output logic signed [abai_pkg::PROD_W-1:0] prod
);
  import abai_pkg::*;

  logic signed [COEF_W-1:0] coef;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [Y_W-1:0]           off_shift;

  assign off_shift = Y_W'({count_offset, {FRAC_BITS{1'b0}}});

  always_comb begin
    case (ctrl.sel)
      MAC_FILTER: begin
        coef = $signed({1'b0, gain});
        diff = $signed({1'b0, avg}) - $signed({1'b0, y});
      end
      MAC_ANGLE: begin
        coef = $signed(COEF_W'(slope));
        diff = $signed({1'b0, y}) - $signed({1'b0, off_shift});
      end
      default: begin
        coef = '0;
        diff = '0;
      end
    endcase
    prod_nxt = coef * diff;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

>>> design/abai_seq.sv
// Sequencer: filter state, saturation, angle clamp and output register.
`include "adc_block_average_iir_angle_defines.svh"

module abai_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  output logic                               in_ready,
  input  logic                               block_done,
  input  logic signed [abai_pkg::PROD_W-1:0] prod,
  input  logic [abai_pkg::ANGLE_W-1:0]       angle_offset,
  output abai_pkg::mac_ctrl_t                mac_ctrl,
  output logic [abai_pkg::Y_W-1:0]           y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [abai_pkg::ANGLE_W-1:0]       out_angle,
  output logic [1:0]                         out_clamp
);
  import abai_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [Y_W-1:0]     y_r, y_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ANGLE_W-1:0] out_angle_r, angle_nxt;
  clamp_t             out_clamp_r, clamp_nxt;
  logic               out_load;
  logic signed [PROD_W:0] y_sum;
  logic signed [PROD_W:0] angle_sum;

  // next state and unit control
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    mac_ctrl.load = 1'b0;
    mac_ctrl.sel  = MAC_FILTER;
    out_load      = 1'b0;
    case (state_r)
      ST_ACC: begin
        in_ready = 1'b1;
        if (block_done) begin
          state_nxt = ST_FILT_MUL;
        end
      end
      ST_FILT_MUL: begin
        mac_ctrl.load = 1'b1;
        state_nxt     = ST_FILT_UPD;
      end
      ST_FILT_UPD: begin
        state_nxt = ST_ANG_MUL;
      end
      ST_ANG_MUL: begin
        mac_ctrl.load = 1'b1;
        mac_ctrl.sel  = MAC_ANGLE;
        state_nxt     = ST_ANG_OUT;
      end
      ST_ANG_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  // y + floor(alpha*diff / 2^16), saturated to the Q12.16 range
  always_comb begin
    y_sum = (PROD_W+1)'($signed({1'b0, y_r})) + (PROD_W+1)'(prod >>> FRAC_BITS);
    y_nxt = y_r;
    if (state_r == ST_FILT_UPD) begin
      if (y_sum[PROD_W]) begin
        y_nxt = '0;
      end else if (|y_sum[PROD_W-1:Y_W]) begin
        y_nxt = '1;
      end else begin
        y_nxt = Y_W'(y_sum);
      end
    end
  end

  // angle = offset + floor(slope*diff / 2^24), clamped to 0..180 deg
  always_comb begin
    angle_sum = (PROD_W+1)'(prod >>> ANGLE_SHIFT)
              + (PROD_W+1)'($signed({1'b0, angle_offset}));
    if (angle_sum[PROD_W]) begin
      angle_nxt = '0;
      clamp_nxt = CLAMP_LOW;
    end else if (angle_sum > (PROD_W+1)'(ANGLE_MAX_Q8)) begin
      angle_nxt = ANGLE_W'(ANGLE_MAX_Q8);
      clamp_nxt = CLAMP_HIGH;
    end else begin
      angle_nxt = ANGLE_W'(angle_sum);
      clamp_nxt = CLAMP_NONE;
    end
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      y_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_angle_r <= angle_nxt;
      out_clamp_r <= clamp_nxt;
    end
  end

  assign y         = y_r;
  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;
  assign out_clamp = out_clamp_r;

  `ABAI_ASSERT_NEXT(a_filt_order, state_r == ST_FILT_MUL, state_r == ST_FILT_UPD)
  `ABAI_ASSERT_IMP(a_clamp_high, out_valid_r && out_clamp_r == CLAMP_HIGH, out_angle_r == ANGLE_W'(ANGLE_MAX_Q8))
  `ABAI_ASSERT_IMP(a_clamp_low, out_valid_r && out_clamp_r == CLAMP_LOW, out_angle_r == '0)
  `ABAI_ASSERT_IMP(a_done_in_acc, block_done, state_r == ST_ACC)

endmodule

>>> design/adc_block_average_iir_angle.sv
// After the transaction carrying a block's last sample, the sequencer steps
//   through FILT_MUL, FILT_UPD, ANG_MUL and ANG_OUT, then out_valid rises. One sample
//   per cycle within a block; between blocks come the two passes through the multiplier.
// in_ready drops in those states, and stays low while a finished result waits.
// Reset (rst_n, synchronous, active low): registers to defaults, position, sum and
//   filter state to zero, no result pending.
module adc_block_average_iir_angle (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [abai_pkg::SAMPLE_BITS-1:0]     in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [abai_pkg::ANGLE_W-1:0]         out_angle_q8,
  output logic [1:0]                           out_clamp_status,
  input  logic                                 cfg_wr_en,
  input  logic [abai_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [abai_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import abai_pkg::*;

  // configuration registers; software must write them only while idle; not enforced
  logic [GAIN_W-1:0]  gain_r;
  logic [COUNT_W-1:0] count_off_r;
  logic [SLOPE_W-1:0] slope_r;
  logic [ANGLE_W-1:0] angle_off_r;

  logic               take_en;
  logic               block_done;
  logic [Y_W-1:0]     avg;
  logic [Y_W-1:0]     y;
  logic signed [PROD_W-1:0] prod;
  mac_ctrl_t          mac_ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RST;
      count_off_r <= COUNT_RST;
      slope_r     <= SLOPE_RST;
      angle_off_r <= ANG_OFF_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FILTER_GAIN:  gain_r      <= cfg_wdata[GAIN_W-1:0];
        CFG_COUNT_OFFSET: count_off_r <= cfg_wdata[COUNT_W-1:0];
        CFG_SLOPE:        slope_r     <= cfg_wdata[SLOPE_W-1:0];
        CFG_ANGLE_OFFSET: angle_off_r <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // a sample transaction
  assign take_en = in_valid & in_ready;

  // running decimated sum; average latched on the block's last sample
  abai_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .take_en    (take_en),
    .sample     (in_sample),
    .block_done (block_done),
    .avg        (avg)
  );

  // one multiplier, used for alpha*(avg - y) and then slope*(y - offset)
  abai_mac u_mac (
    .clk          (clk),
    .ctrl         (mac_ctrl),
    .gain         (gain_r),
    .slope        (slope_r),
    .count_offset (count_off_r),
    .avg          (avg),
    .y            (y),
    .prod         (prod)
  );

  // steps the multiplier, keeps y, clamps and holds the result
  abai_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .block_done   (block_done),
    .prod         (prod),
    .angle_offset (angle_off_r),
    .mac_ctrl     (mac_ctrl),
    .y            (y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_angle    (out_angle_q8),
    .out_clamp    (out_clamp_status)
  );

endmodule

>>> bench/tb_adc_block_average_iir_angle.sv
// Self-checking testbench for the block-average / IIR / angle-mapping block.
`timescale 1ns / 100ps

module tb_adc_block_average_iir_angle;
  import abai_pkg::*;

  // Longest single receiver hold-off used for the backpressure test; it outlasts
  // two back-to-back blocks so the second result has to wait.
  localparam int HOLD_CYCLES = 5000;
  // Cycles without any transaction before the run is declared hung. The
  // worst quiet stretch is the long hold-off above (minus two blocks' time);
  // random stalls and configuration pauses are far shorter.
  localparam int QUIET_LIMIT = 20000;
  // Largest filter state, unsigned Q12.16.
  localparam longint Y_TOP = (longint'(1) << Y_W) - 1;

  typedef struct {
    logic [ANGLE_W-1:0] angle;
    clamp_t             status;
  } angle_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [ANGLE_W-1:0]     out_angle_q8;
  logic [1:0]             out_clamp_status;
  logic                   cfg_wr_en;
  cfg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  adc_block_average_iir_angle DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_angle_q8     (out_angle_q8),
    .out_clamp_status (out_clamp_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // ---------------------------------------------------------------------
  // Predictor: its own copy of calibration and accumulator/filter state.
  // ---------------------------------------------------------------------
  int     gain_cfg   = int'(GAIN_RST);
  int     offset_cfg = int'(COUNT_RST);
  int     slope_cfg  = int'(SLOPE_RST);
  int     aoff_cfg   = int'(ANG_OFF_RST);
  int     cur_pos    = 0;   // position of next sample in its block
  longint cur_sum    = 0;   // sum of decimated samples so far
  longint y_cnt      = 0;   // filtered count, Q12.16

  angle_result_t pending_angles[$];

  // Stimulus shaping knobs, set per test phase.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_req       = 0;   // bumped by a test to ask for a long hold-off

  // Bookkeeping for the summary.
  int samples_sent    = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int mismatches      = 0;

  // Accumulate one accepted sample; at the block's last sample compute the
  // average, step the filter and map to a clamped angle.
  function automatic void absorb_sample(logic [SAMPLE_BITS-1:0] s);
    longint        avg;
    longint        y;
    longint        ang;
    angle_result_t r;
    if (cur_pos % DECIMATION == 0) cur_sum += s;
    if (cur_pos + 1 < BLOCK_SAMPLES) begin
      cur_pos++;
      return;
    end
    avg     = (cur_sum << FRAC_BITS) / TAKEN_COUNT;
    cur_pos = 0;
    cur_sum = 0;
    // >>> on a signed longint floors, matching the round-toward-minus-inf rule
    y = y_cnt + ((longint'(gain_cfg) * (avg - y_cnt)) >>> FRAC_BITS);
    if (y < 0) y = 0;
    if (y > Y_TOP) y = Y_TOP;
    y_cnt = y;
    ang = longint'(aoff_cfg) +
          ((longint'(slope_cfg) * (y - (longint'(offset_cfg) << FRAC_BITS))) >>> ANGLE_SHIFT);
    r.status = CLAMP_NONE;
    if (ang < 0) begin
      ang      = 0;
      r.status = CLAMP_LOW;
    end else if (ang > ANGLE_MAX_Q8) begin
      ang      = ANGLE_MAX_Q8;
      r.status = CLAMP_HIGH;
    end
    r.angle = ANGLE_W'(ang);
    pending_angles.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Sample channel driver. Called aligned to a rising edge; returns at the
  // edge where the transaction was accepted, leaving in_valid high so a
  // following sample can go out back to back.
  // ---------------------------------------------------------------------
  task automatic send_sample(logic [SAMPLE_BITS-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_sample(s);
    samples_sent++;
  endtask

  // One full block: decimated (taken) positions get one value, the rest another.
  task automatic send_block(int taken_val, int other_val);
    for (int i = 0; i < BLOCK_SAMPLES; i++)
      send_sample((i % DECIMATION == 0) ? SAMPLE_BITS'(taken_val) : SAMPLE_BITS'(other_val));
  endtask

  // One block of random content: noise around a level, full-range noise,
  // or rail-to-rail values.
  task automatic send_random_block();
    int mode;
    int base;
    int spread;
    int v;
    mode   = $urandom_range(2);
    base   = $urandom_range(4095);
    spread = $urandom_range(400);
    for (int i = 0; i < BLOCK_SAMPLES; i++) begin
      case (mode)
        0: begin
          v = base + int'($urandom_range(2 * spread)) - spread;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
        end
        1: v = $urandom_range(4095);
        default: v = $urandom_range(1) ? 4095 : 0;
      endcase
      send_sample(SAMPLE_BITS'(v));
    end
  endtask

  // Drop valid, wait for every pending angle, then cover the pipeline latency.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  // Write all four calibration registers while the block is idle.
  task automatic load_calibration(int gain, int offset, int slope, int aoff);
    settle_block();
    write_reg(CFG_FILTER_GAIN, gain);
    write_reg(CFG_COUNT_OFFSET, offset);
    write_reg(CFG_SLOPE, slope);
    write_reg(CFG_ANGLE_OFFSET, aoff);
    cfg_wr_en  <= 1'b0;
    gain_cfg   = gain & 32'h1FFFF;
    offset_cfg = offset & 32'hFFF;
    slope_cfg  = slope & 32'hFFFF;
    aoff_cfg   = aoff & 32'hFFFF;
    settings_loaded++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls, long hold-off on request, and the checker.
  // ---------------------------------------------------------------------
  int hold_ack  = 0;
  int hold_left = 0;

  task automatic check_angle();
    angle_result_t r;
    if (pending_angles.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual angle %0d status %0d",
               $time, out_angle_q8, out_clamp_status);
      mismatches++;
      return;
    end
    r = pending_angles.pop_front();
    results_checked++;
    if (out_angle_q8 !== r.angle) begin
      $display("%0t: angle mismatch, expected %0d actual %0d", $time, r.angle, out_angle_q8);
      mismatches++;
    end
    if (out_clamp_status !== r.status) begin
      $display("%0t: clamp status mismatch, expected %0d actual %0d",
               $time, r.status, out_clamp_status);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_angle();
      if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: any transaction or register write counts as progress.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending_angles.size());
        $display("[adc_block_average_iir_angle] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset calibration, rail inputs: full scale then zero, then mid-scale.
  task automatic test_reset_calibration();
    send_block(4095, 4095);
    send_block(0, 0);
    send_block(2048, 2048);
  endtask

  // Only every DECIMATION-th sample may reach the sum.
  task automatic test_decimation();
    load_calibration(65536, 0, 4096, 0);
    send_block(4095, 0);
    send_block(0, 4095);
    send_block(1365, 2730);
  endtask

  // Exactly 0 and exactly 180 degrees are in range; beyond them clamps.
  task automatic test_angle_limits();
    load_calibration(65536, 0, 0, 0);          // flat map at 0 degrees
    send_block(2000, 2000);
    load_calibration(65536, 0, 0, ANGLE_MAX_Q8); // flat map at 180 degrees
    send_block(2000, 2000);
    load_calibration(65536, 0, 0, 65535);      // offset alone above 180
    send_block(100, 100);
    load_calibration(65536, 4095, 65535, 0);   // far below the offset count
    send_block(0, 0);
    load_calibration(65536, 0, 65535, 0);      // steep slope, high input
    send_block(4095, 4095);
  endtask

  // Filter gain extremes: overshoot both ways, hold, tiny and unity gain.
  task automatic test_filter_gain();
    load_calibration(131071, 300, 3370, 0);
    send_block(4095, 4095);                    // y stays at full scale
    send_block(0, 0);                          // y saturates at zero
    send_block(4095, 4095);
    load_calibration(0, 300, 3370, 0);         // filter frozen
    send_block(0, 0);
    load_calibration(1, 300, 3370, 0);
    send_block(0, 0);
    load_calibration(65536, 1000, 20000, 2560);
    send_block(1234, 1234);
  endtask

  // Receiver holds off while the sender keeps offering: the first result sits
  // in the output register, the second one cannot be handed over, and the
  // third block's samples wait at a stalled input.
  task automatic test_backpressure();
    load_calibration(32768, 300, 3370, 1000);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req <= hold_req + 1;
    send_random_block();
    send_random_block();
    send_random_block();
  endtask

  // Random calibration and content across the four idling regimes.
  task automatic test_random_traffic();
    int gain;
    int offset;
    int slope;
    int aoff;
    int sel;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 19; sink_stall_pct = 19; end
      endcase
      for (int blk = 0; blk < 8; blk++) begin
        if (blk % 2 == 0) begin
          sel = $urandom_range(9);
          if (sel == 0)      gain = 0;
          else if (sel == 1) gain = $urandom_range(131071, 65537);
          else if (sel == 2) gain = 65536;
          else               gain = $urandom_range(65536, 1);
          offset = $urandom_range(1) ? $urandom_range(600) : $urandom_range(4095);
          slope  = $urandom_range(1) ? $urandom_range(5000, 2000) : $urandom_range(65535);
          sel = $urandom_range(4);
          if (sel < 3)       aoff = $urandom_range(8000);
          else if (sel == 3) aoff = $urandom_range(ANGLE_MAX_Q8);
          else               aoff = $urandom_range(65535);
          load_calibration(gain, offset, slope, aoff);
        end
        send_random_block();
      end
    end
  endtask

  initial begin
    in_valid  = 1'b0;
    in_sample = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_FILTER_GAIN;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed blocks run with light idling on both sides
    src_idle_pct   = 19;
    sink_stall_pct = 19;
    test_reset_calibration();
    test_decimation();
    test_angle_limits();
    test_filter_gain();
    test_backpressure();
    test_random_traffic();

    settle_block();
    $display("Covered %0d samples in %0d blocks, %0d calibration loads,", samples_sent,
             samples_sent / BLOCK_SAMPLES, settings_loaded);
    $display("angle clamps both ways, filter overshoot and a long output hold-off.");
    if (mismatches == 0) begin
      $display("[adc_block_average_iir_angle] OK");
    end else begin
      $display("%0d mismatches over %0d results", mismatches, results_checked);
      $display("[adc_block_average_iir_angle] ERROR");
    end
    $finish;
  end

endmodule
